// ----- sv/fpa_pkg.sv -----
`timescale 1ns / 1ps
// Package of the first-fit page allocator: beat types, status and state codes,
// pool geometry and fixed constants. It depends on nothing else.
package fpa_pkg;

  localparam int unsigned MaxShift = 20;
  localparam logic [4:0] PageShiftRst = 5'd12;

  typedef enum logic [1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_POOL_END   = 2'd1,
    REG_PAGE_SHIFT = 2'd2,
    REG_HIGH_FIRST = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOREG = 2'd3
  } status_e;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_SPARE,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] base_address;
    logic [31:0] granted_bytes;
    logic [31:0] peak_bytes;
  } res_t;

  typedef struct packed {
    logic [32:0] lo;
    logic [31:0] hi;
    logic [31:0] npages;
    logic        empty;
    logic [4:0]  sh;
    logic        hif;
  } geom_t;

endpackage

// ----- sv/fpa_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// It depends on nothing else.
module fpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fpa_geom.sv -----
`timescale 1ns / 1ps
// Pool geometry of the allocator: page rounding of the pool bounds and page count.
// It depends on fpa_pkg.
module fpa_geom (
  input  logic [31:0]   pool_base_i,
  input  logic [31:0]   pool_end_i,
  input  logic [4:0]    page_shift_i,
  input  logic          high_first_i,
  output fpa_pkg::geom_t geom_o
);

  logic [4:0]  sh;
  logic [32:0] mask;
  logic [32:0] lo;
  logic [31:0] hi;
  logic        empty;
  logic [32:0] span;

  always_comb begin
    sh    = (page_shift_i > 5'(fpa_pkg::MaxShift)) ? 5'(fpa_pkg::MaxShift) : page_shift_i;
    mask  = (33'd1 << sh) - 33'd1;
    lo    = ({1'b0, pool_base_i} + mask) & ~mask;
    hi    = pool_end_i & ~mask[31:0];
    empty = ({1'b0, hi} <= lo);
    span  = {1'b0, hi} - lo;
    geom_o.lo     = lo;
    geom_o.hi     = hi;
    geom_o.empty  = empty;
    geom_o.npages = empty ? 32'd0 : (span[31:0] >> sh);
    geom_o.sh     = sh;
    geom_o.hif    = high_first_i;
  end

endmodule

// ----- sv/fpa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the allocator: list walk over the region RAM, link updates and results.
// It depends on fpa_pkg and drives one fpa_ram instance through its ports.
module fpa_ctrl #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fpa_pkg::geom_t                      geom_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpa_pkg::req_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpa_pkg::res_t                       out_data_o,
  output logic                                we_o,
  output logic [$clog2(MAX_REGIONS)-1:0]      waddr_o,
  output logic [64+$clog2(MAX_REGIONS+1)-1:0] wdata_o,
  output logic [$clog2(MAX_REGIONS)-1:0]      raddr_o,
  input  logic [64+$clog2(MAX_REGIONS+1)-1:0] rdata_i
);

  localparam int unsigned IW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW = $clog2(MAX_REGIONS);
  localparam logic [IW-1:0] NoneIdx = IW'(MAX_REGIONS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_REGIONS - 1);

  fpa_pkg::state_e  state_q, state_d;
  logic             func_q, func_d;
  logic [31:0]      want_q, want_d;
  logic [31:0]      poff_q, poff_d;
  logic [IW-1:0]    first_q, first_d;
  logic [IW-1:0]    spare_q, spare_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [31:0]      coff_q, coff_d;
  logic [31:0]      cpg_q, cpg_d;
  logic [IW-1:0]    nx_q, nx_d;
  logic [IW-1:0]    node_q, node_d;
  logic [31:0]      noff_q, noff_d;
  logic [31:0]      npg_q, npg_d;
  logic [IW-1:0]    nlnk_q, nlnk_d;
  logic [31:0]      pages_q, pages_d;
  logic [31:0]      peak_q, peak_d;
  fpa_pkg::status_e stat_q, stat_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  fpa_pkg::res_t    out_q, out_d;

  logic [31:0] r_off, r_pg;
  logic [IW-1:0] r_lnk;
  logic [32:0] sub_a, sub_b, room;
  logic        fits, hit, accept, out_free;
  logic [31:0] req_m1, off_base;
  logic [32:0] tot;
  logic [51:0] bytes_w;
  logic [31:0] bytes_sat;
  logic [32:0] r_end, in_off;

  assign r_off = rdata_i[IW+63:IW+32];
  assign r_pg  = rdata_i[IW+31:IW];
  assign r_lnk = rdata_i[IW-1:0];

  assign accept   = in_valid_i && (state_q == fpa_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (state_q == fpa_pkg::S_TAIL) begin
      sub_a = geom_i.hif ? {1'b0, coff_q} : {1'b0, geom_i.npages};
      sub_b = geom_i.hif ? 33'd0 : ({1'b0, coff_q} + {1'b0, cpg_q});
    end else begin
      sub_a = geom_i.hif ? {1'b0, coff_q} : {1'b0, r_off};
      sub_b = geom_i.hif ? ({1'b0, r_off} + {1'b0, r_pg}) : ({1'b0, coff_q} + {1'b0, cpg_q});
    end
    room   = (sub_a > sub_b) ? (sub_a - sub_b) : 33'd0;
    fits   = ({1'b0, want_q} <= room);
    r_end  = {1'b0, r_off} + {1'b0, r_pg};
    hit    = (poff_q >= r_off) && ({1'b0, poff_q} < r_end);
    req_m1 = in_data_i.request_bytes - 32'd1;
    in_off = {1'b0, in_data_i.free_address} - geom_i.lo;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fpa_pkg::S_CLEAR: begin
        if (cnt_q == LastIdx) begin
          state_d = fpa_pkg::S_IDLE;
        end
      end
      fpa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == fpa_pkg::FN_ALLOC) begin
            if (geom_i.empty) begin
              state_d = fpa_pkg::S_DONE;
            end else if (first_q == NoneIdx) begin
              state_d = fpa_pkg::S_TAIL;
            end else begin
              state_d = fpa_pkg::S_WALK;
            end
          end else if (({1'b0, in_data_i.free_address} > {1'b0, geom_i.hi}) ||
                       ({1'b0, in_data_i.free_address} < geom_i.lo) ||
                       (first_q == NoneIdx)) begin
            state_d = fpa_pkg::S_DONE;
          end else begin
            state_d = fpa_pkg::S_WALK;
          end
        end
      end
      fpa_pkg::S_WALK: begin
        if (func_q == fpa_pkg::FN_ALLOC) begin
          if (fits) begin
            state_d = (spare_q == NoneIdx) ? fpa_pkg::S_DONE : fpa_pkg::S_SPARE;
          end else if (r_lnk == NoneIdx) begin
            state_d = fpa_pkg::S_TAIL;
          end
        end else if (hit) begin
          state_d = fpa_pkg::S_WR1;
        end else if (r_lnk == NoneIdx) begin
          state_d = fpa_pkg::S_DONE;
        end
      end
      fpa_pkg::S_TAIL: begin
        if (!fits || (spare_q == NoneIdx)) begin
          state_d = fpa_pkg::S_DONE;
        end else begin
          state_d = fpa_pkg::S_SPARE;
        end
      end
      fpa_pkg::S_SPARE: state_d = fpa_pkg::S_WR1;
      fpa_pkg::S_WR1:   state_d = fpa_pkg::S_WR2;
      fpa_pkg::S_WR2:   state_d = fpa_pkg::S_DONE;
      fpa_pkg::S_DONE: begin
        if (out_free) begin
          state_d = fpa_pkg::S_IDLE;
        end
      end
      default: state_d = fpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    func_d      = func_q;
    want_d      = want_q;
    poff_d      = poff_q;
    first_d     = first_q;
    spare_d     = spare_q;
    cur_d       = cur_q;
    coff_d      = coff_q;
    cpg_d       = cpg_q;
    nx_d        = nx_q;
    node_d      = node_q;
    noff_d      = noff_q;
    npg_d       = npg_q;
    nlnk_d      = nlnk_q;
    pages_d     = pages_q;
    peak_d      = peak_q;
    stat_d      = stat_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we_o        = 1'b0;
    waddr_o     = cur_q[AW-1:0];
    wdata_o     = {coff_q, cpg_q, node_q};
    raddr_o     = nx_q[AW-1:0];
    tot         = {1'b0, pages_q} + {1'b0, want_q};
    bytes_w     = {20'd0, pages_q} << geom_i.sh;
    bytes_sat   = (|bytes_w[51:32]) ? 32'hFFFF_FFFF : bytes_w[31:0];
    off_base    = noff_q << geom_i.sh;
    case (state_q)
      fpa_pkg::S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = cnt_q[AW-1:0];
        wdata_o = {64'd0, cnt_q + IW'(1)};
        cnt_d   = cnt_q + IW'(1);
      end
      fpa_pkg::S_IDLE: begin
        raddr_o = first_q[AW-1:0];
        if (accept) begin
          func_d = in_data_i.func;
          want_d = (in_data_i.request_bytes == 32'd0) ? 32'd0 :
                   ((req_m1 >> geom_i.sh) + 32'd1);
          poff_d = in_off[31:0] >> geom_i.sh;
          cur_d  = NoneIdx;
          coff_d = (geom_i.hif && (in_data_i.func == fpa_pkg::FN_ALLOC)) ?
                   geom_i.npages : 32'd0;
          cpg_d  = 32'd0;
          nx_d   = first_q;
          stat_d = (in_data_i.func == fpa_pkg::FN_ALLOC) ? fpa_pkg::ST_OOM :
                   fpa_pkg::ST_NOREG;
        end
      end
      fpa_pkg::S_WALK: begin
        raddr_o = r_lnk[AW-1:0];
        if (func_q == fpa_pkg::FN_ALLOC) begin
          if (fits) begin
            raddr_o = spare_q[AW-1:0];
            stat_d  = fpa_pkg::ST_FULL;
          end else begin
            cur_d  = nx_q;
            coff_d = r_off;
            cpg_d  = r_pg;
            nx_d   = r_lnk;
          end
        end else if (hit) begin
          node_d = nx_q;
          noff_d = r_off;
          npg_d  = r_pg;
          nlnk_d = r_lnk;
        end else begin
          cur_d  = nx_q;
          coff_d = r_off;
          cpg_d  = r_pg;
          nx_d   = r_lnk;
        end
      end
      fpa_pkg::S_TAIL: begin
        raddr_o = spare_q[AW-1:0];
        stat_d  = fits ? fpa_pkg::ST_FULL : fpa_pkg::ST_OOM;
      end
      fpa_pkg::S_SPARE: begin
        spare_d = r_lnk;
        node_d  = spare_q;
        noff_d  = geom_i.hif ? (coff_q - want_q) : (coff_q + cpg_q);
        npg_d   = want_q;
        nlnk_d  = nx_q;
      end
      fpa_pkg::S_WR1: begin
        if (cur_q == NoneIdx) begin
          first_d = (func_q == fpa_pkg::FN_ALLOC) ? node_q : nlnk_q;
        end else begin
          we_o    = 1'b1;
          wdata_o = {coff_q, cpg_q, (func_q == fpa_pkg::FN_ALLOC) ? node_q : nlnk_q};
        end
        if (func_q == fpa_pkg::FN_ALLOC) begin
          pages_d = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
        end else begin
          pages_d = (pages_q > npg_q) ? (pages_q - npg_q) : 32'd0;
        end
      end
      fpa_pkg::S_WR2: begin
        we_o    = 1'b1;
        waddr_o = node_q[AW-1:0];
        wdata_o = {noff_q, npg_q, (func_q == fpa_pkg::FN_ALLOC) ? nlnk_q : spare_q};
        stat_d  = fpa_pkg::ST_OK;
        if (func_q == fpa_pkg::FN_FREE) begin
          spare_d = node_q;
        end else if (bytes_sat > peak_q) begin
          peak_d = bytes_sat;
        end
      end
      fpa_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status = stat_q;
          out_d.peak_bytes = peak_q;
          if (stat_q == fpa_pkg::ST_OK) begin
            out_d.base_address  = off_base + geom_i.lo[31:0];
            out_d.granted_bytes = npg_q << geom_i.sh;
          end else begin
            out_d.base_address  = 32'd0;
            out_d.granted_bytes = 32'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpa_pkg::S_CLEAR;
      cnt_q       <= '0;
      first_q     <= NoneIdx;
      spare_q     <= '0;
      pages_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      spare_q     <= spare_d;
      pages_q     <= pages_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    want_q <= want_d;
    poff_q <= poff_d;
    cur_q  <= cur_d;
    coff_q <= coff_d;
    cpg_q  <= cpg_d;
    nx_q   <= nx_d;
    node_q <= node_d;
    noff_q <= noff_d;
    npg_q  <= npg_d;
    nlnk_q <= nlnk_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != fpa_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/first_fit_page_allocator.sv -----
`timescale 1ns / 1ps
// First-fit page allocator over a table of regions kept in one synchronous RAM.
// An allocate walks the regions at one RAM read per cycle (at most MAX_REGIONS of them)
// and checks the tail room when no gap fits; a free walks until a region matches or the
// list ends, and errors found at once skip the walk. The block then returns to idle
// before it takes the next beat; a result waits in the output register.
// After reset the free list is built, during which input stalls.
module first_fit_page_allocator #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fpa_pkg::res_t out_data_o
);

  localparam int unsigned IW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW = $clog2(MAX_REGIONS);
  localparam int unsigned EW = 64 + IW;

  logic [31:0] pool_base_q, pool_end_q;
  logic [4:0]  page_shift_q;
  logic        high_first_q;
  fpa_pkg::geom_t geom;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_end_q   <= '0;
      page_shift_q <= fpa_pkg::PageShiftRst;
      high_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpa_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
        fpa_pkg::REG_POOL_END:   pool_end_q   <= cfg_wdata_i;
        fpa_pkg::REG_PAGE_SHIFT: page_shift_q <= cfg_wdata_i[4:0];
        fpa_pkg::REG_HIGH_FIRST: high_first_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  fpa_geom u_geom (
    .pool_base_i  (pool_base_q),
    .pool_end_i   (pool_end_q),
    .page_shift_i (page_shift_q),
    .high_first_i (high_first_q),
    .geom_o       (geom)
  );

  fpa_ctrl #(.MAX_REGIONS(MAX_REGIONS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  fpa_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ----- sv/fpa_chk.sv -----
`timescale 1ns / 1ps
// Port checker of the first-fit page allocator and its bind to the top level.
// It depends on fpa_pkg and first_fit_page_allocator.
module fpa_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fpa_pkg::res_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != fpa_pkg::ST_OK) |->
    (out_data_o.base_address == 32'd0) && (out_data_o.granted_bytes == 32'd0))
    else $error("error result carries a region");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");

endmodule

bind first_fit_page_allocator fpa_chk u_fpa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb_first_fit_page_allocator.sv -----
`timescale 1ns / 1ps
// Testbench of first_fit_page_allocator: named test tasks drive alloc and free beats,
// a built-in predictor tracks the region table and every result is checked in order.
// It depends on fpa_pkg and the first_fit_page_allocator RTL.
module tb_first_fit_page_allocator;
  import fpa_pkg::*;

  localparam int NumRegions = 64;
  localparam logic [63:0] All32 = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] base;
    logic [31:0] bytes;
  } live_region_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  res_t        out_data_o;

  first_fit_page_allocator #(.MAX_REGIONS(NumRegions)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  logic [31:0] pool_base_q = 0, pool_end_q = 0;
  logic [4:0]  page_shift_q = PageShiftRst;
  logic        high_first_q = 1'b0;
  logic [31:0] rg_off [NumRegions];
  logic [31:0] rg_pages [NumRegions];
  int          rg_link [NumRegions];
  int          first_rg = NumRegions;
  int          spare_rg = 0;
  logic [31:0] pages_used = 0;
  logic [31:0] peak_total = 0;

  res_t         pending_results [$];
  live_region_t live_regions [$];
  int           mismatches = 0;
  int           burst_left = 0;

  initial begin
    for (int i = 0; i < NumRegions; i++) rg_link[i] = i + 1;
  end

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return a > b ? a - b : 64'd0;
  endfunction

  function automatic int next_of(int idx);
    return idx >= NumRegions ? first_rg : rg_link[idx];
  endfunction

  function automatic void set_next(int idx, int val);
    if (idx >= NumRegions) first_rg = val;
    else rg_link[idx] = val;
  endfunction

  function automatic res_t predict_result(req_t q);
    logic [4:0]  sh;
    logic [63:0] page, lo, hi, np, want, c_off, c_pg, n_off, n_pg, room, tot, bytes;
    logic [63:0] addr, poff, r_off, r_pg;
    int          cur, nx, node, prv, i;
    bit          ok, found;
    res_t        r;
    sh = page_shift_q > MaxShift ? 5'(MaxShift) : page_shift_q;
    page = 64'd1 << sh;
    lo = ({32'd0, pool_base_q} + page - 1) & ~(page - 1);
    hi = {32'd0, pool_end_q} & ~(page - 1);
    np = hi > lo ? (hi - lo) >> sh : 64'd0;
    r.status = ST_OK;
    r.base_address = '0;
    r.granted_bytes = '0;
    if (q.func == FN_ALLOC) begin
      want = q.request_bytes == 0 ? 64'd0 : (({32'd0, q.request_bytes} - 1) >> sh) + 1;
      if (hi <= lo) begin
        r.status = ST_OOM;
      end else begin
        cur = NumRegions;
        c_off = high_first_q ? np : 64'd0;
        c_pg = 0;
        for (int k = 0; k < NumRegions; k++) begin
          nx = next_of(cur);
          if (nx >= NumRegions) break;
          n_off = rg_off[nx];
          n_pg = rg_pages[nx];
          room = high_first_q ? sat_sub(c_off, n_off + n_pg) : sat_sub(n_off, c_off + c_pg);
          if (want <= room) break;
          cur = nx;
          c_off = n_off;
          c_pg = n_pg;
        end
        ok = 1;
        if (next_of(cur) >= NumRegions) begin
          room = high_first_q ? c_off : sat_sub(np, c_off + c_pg);
          if (room < want) begin
            r.status = ST_OOM;
            ok = 0;
          end
        end
        if (ok && spare_rg >= NumRegions) begin
          r.status = ST_FULL;
          ok = 0;
        end
        if (ok) begin
          node = spare_rg;
          spare_rg = rg_link[node];
          rg_link[node] = next_of(cur);
          set_next(cur, node);
          rg_off[node] = 32'(high_first_q ? c_off - want : c_off + c_pg);
          rg_pages[node] = want[31:0];
          tot = {32'd0, pages_used} + want;
          pages_used = tot > All32 ? 32'hFFFF_FFFF : tot[31:0];
          bytes = {32'd0, pages_used} << sh;
          if (bytes > All32) bytes = All32;
          if (bytes > {32'd0, peak_total}) peak_total = bytes[31:0];
          r.base_address = 32'(({32'd0, rg_off[node]} << sh) + lo);
          r.granted_bytes = 32'(want << sh);
        end
      end
    end else begin
      addr = {32'd0, q.free_address};
      found = 0;
      if (addr <= hi && addr >= lo) begin
        poff = (addr - lo) >> sh;
        i = first_rg;
        prv = NumRegions;
        for (int k = 0; k < NumRegions && i < NumRegions && !found; k++) begin
          r_off = rg_off[i];
          r_pg = rg_pages[i];
          if (poff >= r_off && poff < r_off + r_pg) begin
            set_next(prv, rg_link[i]);
            rg_link[i] = spare_rg;
            spare_rg = i;
            pages_used = 32'(sat_sub({32'd0, pages_used}, r_pg));
            r.base_address = 32'((r_off << sh) + lo);
            r.granted_bytes = 32'(r_pg << sh);
            found = 1;
          end else begin
            prv = i;
            i = rg_link[i];
          end
        end
      end
      if (!found) r.status = ST_NOREG;
    end
    r.peak_bytes = peak_total;
    return r;
  endfunction

  // The sender works in bursts; a gap is only opened between bursts, before valid is raised again.
  task automatic send_beat(func_e fn, logic [31:0] req_bytes, logic [31:0] addr);
    req_t q;
    res_t r;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    q.func = fn;
    q.request_bytes = req_bytes;
    q.free_address = addr;
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_result(q);
    pending_results.push_back(r);
    if (r.status == ST_OK && fn == FN_ALLOC && r.granted_bytes != 0)
      live_regions.push_back('{r.base_address, r.granted_bytes});
    if (r.status == ST_OK && fn == FN_FREE)
      foreach (live_regions[j])
        if (live_regions[j].base == r.base_address) begin
          live_regions.delete(j);
          break;
        end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_pool(logic [31:0] base, logic [31:0] top, logic [4:0] sh, logic hf);
    reg_idx_e idx;
    for (int k = 0; k < 4; k++) begin
      idx = reg_idx_e'(k);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      case (idx)
        REG_POOL_BASE:  cfg_wdata_i <= base;
        REG_POOL_END:   cfg_wdata_i <= top;
        REG_PAGE_SHIFT: cfg_wdata_i <= {27'd0, sh};
        default:        cfg_wdata_i <= {31'd0, hf};
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    pool_base_q = base;
    pool_end_q = top;
    page_shift_q = sh;
    high_first_q = hf;
  endtask

  task automatic free_all();
    live_region_t lr;
    while (live_regions.size() != 0) begin
      lr = live_regions.pop_front();
      send_beat(FN_FREE, 32'd0, lr.base + $urandom_range(0, lr.bytes - 1));
    end
  endtask

  task automatic test_directed();
    wait_idle();
    send_beat(FN_ALLOC, 32'd100, 32'd0);
    send_beat(FN_FREE, 32'd0, 32'd0);
    wait_idle();
    set_pool(32'h0000_1001, 32'h0000_9FFF, 5'd12, 1'b0);
    send_beat(FN_ALLOC, 32'd0, 32'd0);
    send_beat(FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_beat(FN_ALLOC, 32'd1, 32'd0);
    send_beat(FN_ALLOC, 32'h0000_1001, 32'd0);
    send_beat(FN_ALLOC, 32'h0000_3000, 32'd0);
    send_beat(FN_FREE, 32'd0, 32'h0000_3FFF);
    send_beat(FN_ALLOC, 32'h0000_1000, 32'd0);
    send_beat(FN_ALLOC, 32'h0000_1000, 32'd0);
    send_beat(FN_FREE, 32'd0, 32'h0000_0000);
    send_beat(FN_FREE, 32'd0, 32'hFFFF_FFFF);
    send_beat(FN_FREE, 32'd0, 32'h0000_9000);
    send_beat(FN_FREE, 32'd0, 32'h0000_2000);
    wait_idle();
    set_pool(32'h0000_1001, 32'h0000_9FFF, 5'd12, 1'b1);
    send_beat(FN_ALLOC, 32'h0000_2000, 32'd0);
    send_beat(FN_ALLOC, 32'h0000_1000, 32'd0);
    send_beat(FN_ALLOC, 32'h0001_0000, 32'd0);
    free_all();
    wait_idle();
    set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd5, 1'b0);
    send_beat(FN_ALLOC, 32'd1, 32'd0);
    send_beat(FN_FREE, 32'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_full();
    wait_idle();
    set_pool(32'h0010_0000, 32'h0020_0000, 5'd10, 1'b0);
    for (int k = 0; k < NumRegions + 3; k++) send_beat(FN_ALLOC, $urandom_range(1, 1024), 0);
    free_all();
  endtask

  task automatic test_random_phase(logic [31:0] base, logic [31:0] top, logic [4:0] sh,
                                   logic hf, int count, bit keep_live);
    logic [31:0] span, req;
    live_region_t lr;
    int sel;
    if (!keep_live) free_all();
    wait_idle();
    set_pool(base, top, sh, hf);
    span = top > base ? top - base : 32'd1;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        req = (sel < 6) ? $urandom() : $urandom_range(1, span / 5 + 1);
        send_beat(FN_ALLOC, req, $urandom());
      end else if (sel < 85 && live_regions.size() != 0) begin
        lr = live_regions[$urandom_range(0, live_regions.size() - 1)];
        send_beat(FN_FREE, $urandom(), lr.base + $urandom_range(0, lr.bytes - 1));
      end else if (sel < 93) begin
        send_beat(FN_FREE, $urandom(), base + $urandom_range(0, span));
      end else begin
        send_beat(FN_FREE, $urandom(), $urandom());
      end
    end
  endtask

  int   stall_phase = 0;
  int   stall_mode = 0;

  always @(posedge clk_i) begin
    res_t want;
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 2);
    end
    stall_phase--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status
            || out_data_o.base_address !== want.base_address
            || out_data_o.granted_bytes !== want.granted_bytes
            || out_data_o.peak_bytes !== want.peak_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %s base %h bytes %h peak %h, got %s base %h bytes %h peak %h",
                     want.status.name(), want.base_address, want.granted_bytes,
                     want.peak_bytes, out_data_o.status.name(), out_data_o.base_address,
                     out_data_o.granted_bytes, out_data_o.peak_bytes);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_table_full();
    test_random_phase(32'h0000_1000, 32'h0004_1000, 5'd12, 1'b0, 300, 0);
    test_random_phase(32'h0000_1000, 32'h0004_1000, 5'd12, 1'b1, 300, 1);
    test_random_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 5'd0, 1'b0, 250, 0);
    test_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 5'd31, 1'b1, 250, 0);
    test_random_phase(32'h8000_0123, 32'h8004_0FFF, 5'd20, 1'b0, 150, 0);
    for (int p = 0; p < 3; p++)
      test_random_phase($urandom(), $urandom(), 5'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)), 100, 0);
    test_random_phase(32'h0000_0040, 32'h0000_1040, 5'd6, 1'b1, 250, 0);
    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
